/* sv/btmx_pkg.sv */
// ----------------------------------------------------------------------------
// btmx_pkg
// Shared constants and types for the binary trie maximum XOR pair block.
// ----------------------------------------------------------------------------
`default_nettype none

package btmx_pkg;

    localparam int KEY_BITS   = 32;
    localparam int NODE_COUNT = 8192;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int CNT_W      = $clog2(NODE_COUNT + 1);
    localparam int LVL_W      = $clog2(KEY_BITS);
    localparam int NEED_W     = $clog2(KEY_BITS + 1);
    localparam int KIDS_W     = 2 * NODE_W;

    typedef struct packed {
        logic [NODE_W-1:0] hi;
        logic [NODE_W-1:0] lo;
    } t_kids;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        logic [KIDS_W-1:0] wdata;
        logic              re;
        logic [NODE_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic [KEY_BITS-1:0] pair_xor;
        logic [KEY_BITS-1:0] set_max;
        logic                pool_full;
    } t_result;

endpackage

`default_nettype wire

/* sv/btmx_ram.sv */
// ----------------------------------------------------------------------------
// btmx_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/btmx_ctrl.sv */
// ----------------------------------------------------------------------------
// btmx_ctrl
// Sequencer that walks the node memory to insert a key, when the node pool
// has room, and then to find the largest XOR of the key with any stored key.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic [btmx_pkg::KEY_BITS-1:0] i_value,
    input  wire logic                         i_last_of_set,
    output logic                              o_in_stall,
    output btmx_pkg::t_ram_req                o_ram,
    input  wire logic [btmx_pkg::KIDS_W-1:0]  i_rd_data,
    output logic                              o_res_valid,
    output btmx_pkg::t_result                 o_res,
    input  wire logic                         i_res_take
);

    import btmx_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_INS  = 7'b0000010,
        S_CHK  = 7'b0000100,
        S_ATT  = 7'b0001000,
        S_NEW  = 7'b0010000,
        S_QRY  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic                r_last, n_last;
    logic [LVL_W-1:0]    r_lvl, n_lvl;
    logic [NODE_W-1:0]   r_node, n_node;
    logic                r_at_root, n_at_root;
    t_kids               r_kids, n_kids;
    t_kids               r_root, n_root;
    logic [CNT_W-1:0]    r_free, n_free;
    logic [KEY_BITS-1:0] r_max, n_max;
    logic [KEY_BITS-1:0] r_acc, n_acc;
    logic                r_ok, n_ok;

    t_kids               w_cur;
    t_kids               w_att;
    t_kids               w_new;
    logic                w_bit;
    logic [NODE_W-1:0]   w_same;
    logic [NODE_W-1:0]   w_opp;
    logic [NODE_W-1:0]   w_qnext;
    logic [NODE_W-1:0]   w_fresh;
    logic [LVL_W-1:0]    w_lvl_dn;
    logic [NEED_W-1:0]   w_need;
    logic [CNT_W:0]      w_sum;
    logic                w_short;
    logic [KEY_BITS-1:0] w_max_new;

    always_comb begin
        w_cur     = r_at_root ? r_root : t_kids'(i_rd_data);
        w_bit     = r_key[r_lvl];
        w_same    = w_bit ? w_cur.hi : w_cur.lo;
        w_opp     = w_bit ? w_cur.lo : w_cur.hi;
        w_qnext   = (w_opp != '0) ? w_opp : w_same;
        w_fresh   = r_free[NODE_W-1:0];
        w_lvl_dn  = r_lvl - 1'b1;
        w_need    = NEED_W'(r_lvl) + 1'b1;
        w_sum     = {1'b0, r_free} + (CNT_W+1)'(w_need);
        w_short   = w_sum > (CNT_W+1)'(NODE_COUNT);
        w_max_new = (r_acc > r_max) ? r_acc : r_max;

        w_att = r_kids;
        if (w_bit) begin
            w_att.hi = w_fresh;
        end else begin
            w_att.lo = w_fresh;
        end

        w_new = '0;
        if (r_lvl != '0) begin
            if (r_key[w_lvl_dn]) begin
                w_new.hi = w_fresh + 1'b1;
            end else begin
                w_new.lo = w_fresh + 1'b1;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_key     = r_key;
        n_last    = r_last;
        n_lvl     = r_lvl;
        n_node    = r_node;
        n_at_root = r_at_root;
        n_kids    = r_kids;
        n_root    = r_root;
        n_free    = r_free;
        n_max     = r_max;
        n_acc     = r_acc;
        n_ok      = r_ok;

        o_ram.we    = 1'b0;
        o_ram.waddr = r_node;
        o_ram.wdata = KIDS_W'(r_kids);
        o_ram.re    = 1'b0;
        o_ram.raddr = w_same;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key     = i_value;
                    n_last    = i_last_of_set;
                    n_lvl     = LVL_W'(KEY_BITS - 1);
                    n_at_root = 1'b1;
                    n_state   = S_INS;
                end
            end
            S_INS: begin
                if (w_same == '0) begin
                    n_kids  = w_cur;
                    n_state = S_CHK;
                end else if (r_lvl == '0) begin
                    n_ok      = 1'b1;
                    n_lvl     = LVL_W'(KEY_BITS - 1);
                    n_at_root = 1'b1;
                    n_acc     = '0;
                    n_state   = S_QRY;
                end else begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = w_same;
                    n_node      = w_same;
                    n_at_root   = 1'b0;
                    n_lvl       = w_lvl_dn;
                end
            end
            S_CHK: begin
                if (w_short) begin
                    n_ok      = 1'b0;
                    n_lvl     = LVL_W'(KEY_BITS - 1);
                    n_at_root = 1'b1;
                    n_acc     = '0;
                    n_state   = S_QRY;
                end else begin
                    n_ok    = 1'b1;
                    n_state = S_ATT;
                end
            end
            S_ATT: begin
                if (r_at_root) begin
                    n_root = w_att;
                end else begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_node;
                    o_ram.wdata = KIDS_W'(w_att);
                end
                n_state = S_NEW;
            end
            S_NEW: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = w_fresh;
                o_ram.wdata = KIDS_W'(w_new);
                n_free      = r_free + 1'b1;
                if (r_lvl == '0) begin
                    n_lvl     = LVL_W'(KEY_BITS - 1);
                    n_at_root = 1'b1;
                    n_acc     = '0;
                    n_state   = S_QRY;
                end else begin
                    n_lvl = w_lvl_dn;
                end
            end
            S_QRY: begin
                if (w_opp != '0) begin
                    n_acc[r_lvl] = 1'b1;
                end
                if (w_qnext == '0 || r_lvl == '0) begin
                    n_state = S_DONE;
                end else begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = w_qnext;
                    n_at_root   = 1'b0;
                    n_lvl       = w_lvl_dn;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_max   = w_max_new;
                    n_state = S_IDLE;
                    if (r_last) begin
                        n_root = '0;
                        n_free = CNT_W'(1);
                        n_max  = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_root  <= '0;
            r_free  <= CNT_W'(1);
            r_max   <= '0;
        end else begin
            r_state <= n_state;
            r_root  <= n_root;
            r_free  <= n_free;
            r_max   <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_last    <= n_last;
        r_lvl     <= n_lvl;
        r_node    <= n_node;
        r_at_root <= n_at_root;
        r_kids    <= n_kids;
        r_acc     <= n_acc;
        r_ok      <= n_ok;
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_res_valid       = (r_state == S_DONE);
    assign o_res.pair_xor    = r_acc;
    assign o_res.set_max     = w_max_new;
    assign o_res.pool_full   = ~r_ok;

endmodule

`default_nettype wire

/* sv/binary_trie_max_xor_pair_top.sv */
// ----------------------------------------------------------------------------
// binary_trie_max_xor_pair_top
// Streams 32-bit values into a binary trie and returns, for each value, the
// largest XOR with any stored value and the running maximum of it in the set.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid with i_value and i_last_of_set; the block holds
// o_in_stall high while it works on a request and takes a new one only when
// idle. Output channel: o_out_valid with o_pair_xor, o_set_max and
// o_pool_full; the receiver holds i_out_stall high to keep the result.
// Every request gives exactly one result.
// A request first walks the insert path and then the query path; nothing is
// written when its value is already stored, and the insert is skipped when
// the node pool is too short. The insert walk reads one trie level per cycle
// until the path ends, the parent link and each missing node are then
// written one per cycle, and the query walk reads one level per cycle again.
// The single node memory paces these walks. The next request is accepted
// once the sequencer has loaded the result and returned to idle.
// The result register frees the sequencer, so a new request is accepted
// while an earlier result waits; the block waits only when its next result
// is ready and the previous one is still stalled.
// After reset the trie is empty, the node counter starts at one and the
// running maximum is zero; no memory clearing pass is needed. A request
// marked as last of set clears the trie once its result is produced.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_trie_max_xor_pair_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic [btmx_pkg::KEY_BITS-1:0] i_value,
    input  wire logic                          i_last_of_set,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output logic      [btmx_pkg::KEY_BITS-1:0] o_pair_xor,
    output logic      [btmx_pkg::KEY_BITS-1:0] o_set_max,
    output logic                               o_pool_full,
    input  wire logic                          i_out_stall
);

    import btmx_pkg::*;

    t_ram_req          w_ram;
    logic [KIDS_W-1:0] w_rd_data;
    logic              w_res_valid;
    t_result           w_res;
    logic              w_take;
    logic              r_out_valid;
    t_result           r_out;

    btmx_ram #(
        .WIDTH (KIDS_W),
        .DEPTH (NODE_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rd_data)
    );

    btmx_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_value       (i_value),
        .i_last_of_set (i_last_of_set),
        .o_in_stall    (o_in_stall),
        .o_ram         (w_ram),
        .i_rd_data     (w_rd_data),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res),
        .i_res_take    (w_take)
    );

    assign w_take = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pair_xor  = r_out.pair_xor;
    assign o_set_max   = r_out.set_max;
    assign o_pool_full = r_out.pool_full;

`ifndef SYNTHESIS
    a_max_covers_xor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_set_max >= o_pair_xor))
        else $error("set maximum below pair XOR");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while sequencer not busy afterwards");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_take) |=> (o_out_valid && !$past(o_in_stall) == 1'b0))
        else $error("finished result not loaded into output register");
`endif

endmodule

`default_nettype wire
